/* design/uss_pkg.sv */
// ----------------------------------------------------------------------------
// uss_pkg
// shared types and constants of the upstream server selector
// ----------------------------------------------------------------------------
package uss_pkg;

  localparam int TAG_W      = 8;
  localparam int SRV_IDX_W  = 4;
  localparam int STATUS_W   = 2;
  localparam int SCOUNT_W   = 5;
  localparam int MASK_W     = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SERVERS   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE_HEALTHY = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SERVER_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEALTHY_MASK = 2'd2;

  // balancing modes
  localparam logic MODE_ROUND_ROBIN = 1'b0;
  localparam logic MODE_LEAST_CONN  = 1'b1;

  typedef struct packed {
    logic                mode;
    logic [SCOUNT_W-1:0] server_count;
    logic [MASK_W-1:0]   healthy_mask;
  } cfg_t;

  typedef struct packed {
    logic [SRV_IDX_W-1:0] server_index;
    logic [STATUS_W-1:0]  status;
    logic [TAG_W-1:0]     echo_tag;
  } result_t;

endpackage

/* design/uss_req_if.sv */
// ----------------------------------------------------------------------------
// uss_req_if
// request channel: valid/ready with the request tag
// ----------------------------------------------------------------------------
interface uss_req_if
  import uss_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [TAG_W-1:0] request_tag;

  modport source (output valid, output request_tag, input ready);
  modport sink   (input valid, input request_tag, output ready);
endinterface

/* design/uss_res_if.sv */
// ----------------------------------------------------------------------------
// uss_res_if
// result channel: valid/ready with server index, status and echoed tag
// ----------------------------------------------------------------------------
interface uss_res_if
  import uss_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [SRV_IDX_W-1:0] server_index;
  logic [STATUS_W-1:0]  status;
  logic [TAG_W-1:0]     echo_tag;

  modport source (output valid, output server_index, output status, output echo_tag,
                  input ready);
  modport sink   (input valid, input server_index, input status, input echo_tag,
                  output ready);
endinterface

/* design/uss_count_mem.sv */
// ----------------------------------------------------------------------------
// uss_count_mem
// connection counter memory, one write and one registered read port,
// per-entry valid bits so that unwritten counters read as zero
// ----------------------------------------------------------------------------
module uss_count_mem #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid_r;
  logic [DATA_W-1:0] rdata_r;
  logic              rvalid_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      rvalid_r <= valid_r[raddr];
    end
  end

  assign rdata = rvalid_r ? rdata_r : '0;

endmodule

/* design/uss_seq.sv */
// ----------------------------------------------------------------------------
// uss_seq
// selection sequencer: one server per cycle through a shared compare unit,
// then a read-increment-write of the chosen counter
// ----------------------------------------------------------------------------
module uss_seq
  import uss_pkg::*;
#(
  parameter int MAX_SERVERS = 16,
  parameter int COUNT_WIDTH = 16,
  parameter int IDX_W       = 4,
  parameter int CNT_W       = 5
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  logic                   req_valid,
  input  logic [TAG_W-1:0]       req_tag,
  output logic                   req_ready,
  output logic                   res_valid,
  output result_t                res,
  input  logic                   res_take,
  output logic [IDX_W-1:0]       mem_raddr,
  input  logic [COUNT_WIDTH-1:0] mem_rdata,
  output logic                   mem_we,
  output logic [IDX_W-1:0]       mem_waddr,
  output logic [COUNT_WIDTH-1:0] mem_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RD,
    S_INC,
    S_DONE
  } state_t;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [IDX_W-1:0]       ptr_r, ptr_nxt;
  logic [IDX_W-1:0]       p_r, p_nxt;
  logic [IDX_W-1:0]       start_r, start_nxt;
  logic [IDX_W-1:0]       chosen_r, chosen_nxt;
  logic                   found_r, found_nxt;
  logic [COUNT_WIDTH-1:0] best_r, best_nxt;
  logic                   cmp_v_r, cmp_v_nxt;
  logic [IDX_W-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic [TAG_W-1:0]       tag_r, tag_nxt;
  logic [STATUS_W-1:0]    status_r, status_nxt;

  logic [MAX_SERVERS-1:0] health;
  logic [CNT_W-1:0]       count_eff;
  logic [IDX_W-1:0]       start;
  logic [IDX_W-1:0]       p_wrap;

  // servers past the mask width have no health bit
  for (genvar j = 0; j < MAX_SERVERS; j++) begin : g_health
    if (j < MASK_W) begin : g_bit
      assign health[j] = cfg.healthy_mask[j];
    end else begin : g_none
      assign health[j] = 1'b0;
    end
  end

  assign count_eff = (32'(cfg.server_count) > MAX_SERVERS) ? CNT_W'(MAX_SERVERS)
                                                           : CNT_W'(cfg.server_count);
  assign start     = (CNT_W'(ptr_r) >= count_eff) ? '0 : ptr_r;
  assign p_wrap    = ((CNT_W'(p_r) + CNT_W'(1)) == count_eff) ? '0 : p_r + IDX_W'(1);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    ptr_nxt     = ptr_r;
    p_nxt       = p_r;
    start_nxt   = start_r;
    chosen_nxt  = chosen_r;
    found_nxt   = found_r;
    best_nxt    = best_r;
    cmp_v_nxt   = cmp_v_r;
    cmp_idx_nxt = cmp_idx_r;
    tag_nxt     = tag_r;
    status_nxt  = status_r;
    req_ready   = 1'b0;
    res_valid   = 1'b0;
    mem_raddr   = chosen_r;
    mem_we      = 1'b0;
    mem_waddr   = chosen_r;
    mem_wdata   = mem_rdata + COUNT_WIDTH'(1);

    case (state_r)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          tag_nxt    = req_tag;
          status_nxt = ST_OK;
          chosen_nxt = '0;
          cnt_nxt    = '0;
          found_nxt  = 1'b0;
          cmp_v_nxt  = 1'b0;
          p_nxt      = start;
          start_nxt  = start;
          if (count_eff == '0) begin
            status_nxt = ST_NO_SERVERS;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cfg.mode == MODE_ROUND_ROBIN) begin
          if (health[p_r]) begin
            chosen_nxt = p_r;
            found_nxt  = 1'b1;
            ptr_nxt    = p_wrap;
            state_nxt  = S_RD;
          end else if (cnt_r == count_eff - CNT_W'(1)) begin
            ptr_nxt    = start_r;
            status_nxt = ST_NONE_HEALTHY;
            chosen_nxt = '0;
            state_nxt  = S_DONE;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
            p_nxt   = p_wrap;
          end
        end else begin
          // read issue side
          mem_raddr = cnt_r[IDX_W-1:0];
          if (cnt_r != count_eff) begin
            cmp_v_nxt   = 1'b1;
            cmp_idx_nxt = cnt_r[IDX_W-1:0];
            cnt_nxt     = cnt_r + CNT_W'(1);
          end else begin
            cmp_v_nxt = 1'b0;
          end
          // compare side, works on the read issued in the cycle before
          if (cmp_v_r && health[cmp_idx_r] && (!found_r || mem_rdata < best_r)) begin
            best_nxt   = mem_rdata;
            chosen_nxt = cmp_idx_r;
            found_nxt  = 1'b1;
          end
          if (cnt_r == count_eff && !cmp_v_r) begin
            if (found_r) begin
              state_nxt = S_RD;
            end else begin
              status_nxt = ST_NONE_HEALTHY;
              chosen_nxt = '0;
              state_nxt  = S_DONE;
            end
          end
        end
      end
      S_RD: begin
        state_nxt = S_INC;
      end
      S_INC: begin
        mem_we    = (mem_rdata != COUNT_MAX);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ptr_r   <= '0;
      cmp_v_r <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      cmp_v_r <= cmp_v_nxt;
      found_r <= found_nxt;
    end
    cnt_r     <= cnt_nxt;
    p_r       <= p_nxt;
    start_r   <= start_nxt;
    chosen_r  <= chosen_nxt;
    best_r    <= best_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    tag_r     <= tag_nxt;
    status_r  <= status_nxt;
  end

  assign res.server_index = SRV_IDX_W'(chosen_r);
  assign res.status       = status_r;
  assign res.echo_tag     = tag_r;

endmodule

/* design/upstream_server_selector.sv */
// ----------------------------------------------------------------------------
// upstream_server_selector
// round-robin / least-connections upstream selection with saturating
// per-server connection counters
// ----------------------------------------------------------------------------
// round robin probes servers from the pointer until a healthy one; least connections
//   reads and compares every counter; then counter read, increment and result; a scan
//   with no healthy server, and a zero server count, go straight to the result, the
//   latter leaving pointer and counters alone; one request at a time, set by the scan
//   and the counter update; the next request is accepted after the result is handed off
// synchronous active-low reset clears configuration, state, pointer and counter valid bits
// ----------------------------------------------------------------------------
module upstream_server_selector
  import uss_pkg::*;
#(
  parameter int MAX_SERVERS = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  uss_req_if.sink               in_req,
  uss_res_if.source             out_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // index wide enough for any server, count wide enough for the full depth
  localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int CNT_W = $clog2(MAX_SERVERS + 1);

  cfg_t cfg_r;

  // configuration registers, writes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:         cfg_r.mode         <= cfg_wdata[0];
        REG_SERVER_COUNT: cfg_r.server_count <= cfg_wdata[SCOUNT_W-1:0];
        REG_HEALTHY_MASK: cfg_r.healthy_mask <= cfg_wdata[MASK_W-1:0];
        default:          cfg_r              <= cfg_r;
      endcase
    end
  end

  logic                   seq_res_valid;
  result_t                seq_res;
  logic                   res_take;
  logic [IDX_W-1:0]       mem_raddr;
  logic [COUNT_WIDTH-1:0] mem_rdata;
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  logic [COUNT_WIDTH-1:0] mem_wdata;

  // sequencer: scan, compare and counter update
  uss_seq #(
    .MAX_SERVERS (MAX_SERVERS),
    .COUNT_WIDTH (COUNT_WIDTH),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .req_valid (in_req.valid),
    .req_tag   (in_req.request_tag),
    .req_ready (in_req.ready),
    .res_valid (seq_res_valid),
    .res       (seq_res),
    .res_take  (res_take),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata)
  );

  // per-server connection counters
  uss_count_mem #(
    .DEPTH  (MAX_SERVERS),
    .DATA_W (COUNT_WIDTH),
    .ADDR_W (IDX_W)
  ) u_count_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register: the sequencer hands off its result beat and goes idle
  // while the beat waits downstream
  logic    out_valid_r;
  result_t out_res_r;

  assign res_take = seq_res_valid && (!out_valid_r || out_res.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
    if (res_take) begin
      out_res_r <= seq_res;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.server_index = out_res_r.server_index;
  assign out_res.status       = out_res_r.status;
  assign out_res.echo_tag     = out_res_r.echo_tag;

endmodule

/* design/uss_checker.sv */
// ----------------------------------------------------------------------------
// uss_checker
// port-level assertions for the upstream server selector
// ----------------------------------------------------------------------------
module uss_checker
  import uss_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [SRV_IDX_W-1:0] out_server_index,
  input logic [STATUS_W-1:0]  out_status,
  input logic [TAG_W-1:0]     out_echo_tag
);

  // only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_NO_SERVERS ||
                   out_status == ST_NONE_HEALTHY))
    else $error("undefined status code on result beat");

  // an error result carries server index zero
  a_err_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_server_index == '0))
    else $error("error result with nonzero server index");

  // one request at a time: busy right after an accepted beat
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while previous one still in work");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_server_index) &&
                                   $stable(out_status) && $stable(out_echo_tag)))
    else $error("stalled result beat changed");

endmodule

bind upstream_server_selector uss_checker u_uss_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_req.valid),
  .in_ready         (in_req.ready),
  .out_valid        (out_res.valid),
  .out_ready        (out_res.ready),
  .out_server_index (out_res.server_index),
  .out_status       (out_res.status),
  .out_echo_tag     (out_res.echo_tag)
);
